// ===== hw/rtl/rot_pkg.sv =====
// rot_pkg: shared types and constants for the clockwise image rotator
// pixel and result item layouts, register indexes of the csr port
// no dependencies

package rot_pkg;

   // csr port layout
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 7;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_WIDTH  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_HEIGHT = 1'b1;

   // depth of the queue between front and back
   localparam int QUEUE_DEPTH = 4;

   // incoming raster pixel
   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } pixel_type;

   // rotated pixel of the previous frame
   typedef struct packed {
      logic [7:0] out_red;
      logic [7:0] out_green;
      logic [7:0] out_blue;
      logic       out_valid;
      logic       out_last;
   } result_type;

endpackage

// ===== hw/rtl/rot_front.sv =====
// rot_front: accepts pixels, holds the frame registers and the write/read counters
// and turns each item into a write address plus read coordinates for the back end
// depends on rot_pkg

module rot_front #(
   parameter int MAX_WIDTH  = 64,
   parameter int MAX_HEIGHT = 64,
   localparam int WW      = $clog2(MAX_WIDTH + 1),
   localparam int HW      = $clog2(MAX_HEIGHT + 1),
   localparam int BANK    = MAX_WIDTH * MAX_HEIGHT,
   localparam int ADDR_W  = $clog2(2 * BANK),
   localparam int ENTRY_W = 24 + ADDR_W + 3 + HW + WW
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  rot_pkg::pixel_type                 req_data,
   input  logic                               csr_valid,
   input  logic [rot_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [rot_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  logic                               q_full,
   output logic                               q_push,
   output logic [ENTRY_W-1:0]                 q_entry,
   output logic [WW-1:0]                      width
);

   localparam int IDX_W = $clog2(BANK + 1);
   localparam int CW    = rot_pkg::CSR_DATA_W + WW + HW;
   localparam int W_RST = (64 > MAX_WIDTH) ? MAX_WIDTH : 64;
   localparam int H_RST = (64 > MAX_HEIGHT) ? MAX_HEIGHT : 64;

   typedef struct packed {
      rot_pkg::pixel_type  pix;
      logic [ADDR_W-1:0]   wr_addr;
      logic                rd_on;
      logic                rd_bank;
      logic [HW-1:0]       rd_base;
      logic [WW-1:0]       rd_row;
      logic                last;
   } entry_type;

   logic [WW-1:0]    width_ff, width_in;
   logic [HW-1:0]    height_ff, height_in;
   logic [IDX_W-1:0] total_ff, total_in;
   logic             settle_ff, settle_in;
   logic             write_bank_ff, write_bank_in;
   logic [IDX_W-1:0] write_index_ff, write_index_in;
   logic [WW-1:0]    read_row_ff, read_row_in;
   logic [HW-1:0]    read_col_ff, read_col_in;
   logic             prev_ready_ff, prev_ready_in;

   logic [CW-1:0]    csr_val;
   logic [CW-1:0]    w_clamp;
   logic [CW-1:0]    h_clamp;
   logic             last_pos;
   logic [IDX_W-1:0] idx;
   logic [WW-1:0]    rr;
   logic [HW-1:0]    rc;
   logic             col_wrap;
   logic             row_wrap;
   entry_type        entry;

   // clamp written dimensions into 1..max
   always_comb begin
      csr_val = CW'(csr_wdata);
      w_clamp = (csr_val == '0) ? CW'(1) :
                ((csr_val > CW'(MAX_WIDTH)) ? CW'(MAX_WIDTH) : csr_val);
      h_clamp = (csr_val == '0) ? CW'(1) :
                ((csr_val > CW'(MAX_HEIGHT)) ? CW'(MAX_HEIGHT) : csr_val);
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_valid && csr_index == rot_pkg::CSR_FRAME_WIDTH) begin
         width_in = w_clamp[WW-1:0];
      end
      if (csr_valid && csr_index == rot_pkg::CSR_FRAME_HEIGHT) begin
         height_in = h_clamp[HW-1:0];
      end
      total_in  = IDX_W'(width_ff * height_ff);
      settle_in = csr_valid;
   end

   // hold off items in the cycle after a write so the frame size settles
   assign req_ready = !q_full && !settle_ff;
   assign q_push    = req_valid && req_ready;
   assign width     = width_ff;

   // classify the item: write slot, read coordinates, end of rotated frame
   always_comb begin
      last_pos = ({1'b0, write_index_ff} + (IDX_W + 1)'(1)) >= {1'b0, total_ff};
      idx      = (write_index_ff < total_ff) ? write_index_ff : total_ff - IDX_W'(1);
      rr       = (read_row_ff < width_ff) ? read_row_ff : width_ff - WW'(1);
      rc       = (read_col_ff < height_ff) ? read_col_ff : height_ff - HW'(1);
      col_wrap = ({1'b0, read_col_ff} + (HW + 1)'(1)) >= {1'b0, height_ff};
      row_wrap = ({1'b0, read_row_ff} + (WW + 1)'(1)) >= {1'b0, width_ff};

      entry.pix     = req_data;
      entry.wr_addr = write_bank_ff ? ADDR_W'(BANK) + ADDR_W'(idx) : ADDR_W'(idx);
      entry.rd_on   = prev_ready_ff;
      entry.rd_bank = !write_bank_ff;
      entry.rd_base = height_ff - HW'(1) - rc;
      entry.rd_row  = rr;
      entry.last    = prev_ready_ff && (read_row_ff == width_ff - WW'(1)) &&
                      (read_col_ff == height_ff - HW'(1));
      q_entry       = entry;
   end

   // counter updates per accepted item
   always_comb begin
      write_bank_in  = write_bank_ff;
      write_index_in = write_index_ff;
      read_row_in    = read_row_ff;
      read_col_in    = read_col_ff;
      prev_ready_in  = prev_ready_ff;
      if (q_push) begin
         if (prev_ready_ff) begin
            if (col_wrap) begin
               read_col_in = '0;
               read_row_in = row_wrap ? '0 : read_row_ff + WW'(1);
            end else begin
               read_col_in = read_col_ff + HW'(1);
            end
         end
         if (last_pos) begin
            write_bank_in  = !write_bank_ff;
            write_index_in = '0;
            read_row_in    = '0;
            read_col_in    = '0;
            prev_ready_in  = 1'b1;
         end else begin
            write_index_in = write_index_ff + IDX_W'(1);
         end
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff       <= WW'(W_RST);
         height_ff      <= HW'(H_RST);
         total_ff       <= IDX_W'(W_RST * H_RST);
         settle_ff      <= 1'b0;
         write_bank_ff  <= 1'b0;
         write_index_ff <= '0;
         read_row_ff    <= '0;
         read_col_ff    <= '0;
         prev_ready_ff  <= 1'b0;
      end else begin
         width_ff       <= width_in;
         height_ff      <= height_in;
         total_ff       <= total_in;
         settle_ff      <= settle_in;
         write_bank_ff  <= write_bank_in;
         write_index_ff <= write_index_in;
         read_row_ff    <= read_row_in;
         read_col_ff    <= read_col_in;
         prev_ready_ff  <= prev_ready_in;
      end
   end

   // frame completion swaps banks and restarts the counters
   assert property (@(posedge clock) disable iff (reset)
      (q_push && last_pos) |=> (write_index_ff == '0 && prev_ready_ff))
      else $error("frame completion did not restart the write counter");

   // no item slips in right after a register write
   assert property (@(posedge clock) disable iff (reset)
      csr_valid |=> !q_push)
      else $error("item accepted while frame size settles");

endmodule

// ===== hw/rtl/rot_queue.sv =====
// rot_queue: small fifo between the front and back of the rotator
// depends on nothing but its parameters

module rot_queue #(
   parameter int DATA_W = 8,
   parameter int DEPTH  = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic [DATA_W-1:0] push_data,
   output logic              full,
   input  logic              pop,
   output logic              head_valid,
   output logic [DATA_W-1:0] head_data
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [DATA_W-1:0] slot_ff [DEPTH];
   logic [PW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_data  = slot_ff[rd_ptr_ff];

   // pointer and fill count updates
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // slot storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   assert property (@(posedge clock) disable iff (reset) !(push && full && !pop))
      else $error("push into a full queue");

   assert property (@(posedge clock) disable iff (reset) !(pop && count_ff == '0))
      else $error("pop from an empty queue");

endmodule

// ===== hw/rtl/rot_back.sv =====
// rot_back: computes the rotated read address, accesses the double-buffered
// frame store and holds the result item until it is taken
// depends on rot_pkg

module rot_back #(
   parameter int MAX_WIDTH  = 64,
   parameter int MAX_HEIGHT = 64,
   localparam int WW      = $clog2(MAX_WIDTH + 1),
   localparam int HW      = $clog2(MAX_HEIGHT + 1),
   localparam int BANK    = MAX_WIDTH * MAX_HEIGHT,
   localparam int ADDR_W  = $clog2(2 * BANK),
   localparam int ENTRY_W = 24 + ADDR_W + 3 + HW + WW
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [WW-1:0]        width,
   input  logic                 q_valid,
   input  logic [ENTRY_W-1:0]   q_entry,
   output logic                 q_pop,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rot_pkg::result_type  rsp_data
);

   localparam int SW = WW + HW + 1;

   typedef struct packed {
      rot_pkg::pixel_type  pix;
      logic [ADDR_W-1:0]   wr_addr;
      logic                rd_on;
      logic                rd_bank;
      logic [HW-1:0]       rd_base;
      logic [WW-1:0]       rd_row;
      logic                last;
   } entry_type;

   entry_type          head;
   logic               adv;
   logic [SW-1:0]      src_sum;

   // address stage
   logic               a_valid_ff;
   rot_pkg::pixel_type a_pix_ff;
   logic [ADDR_W-1:0]  a_wr_addr_ff;
   logic [ADDR_W-1:0]  a_rd_addr_ff;
   logic               a_rd_on_ff;
   logic               a_last_ff;

   // memory / output stage
   logic               b_valid_ff;
   rot_pkg::pixel_type rd_data_ff;
   logic               b_rd_on_ff;
   logic               b_last_ff;

   rot_pkg::pixel_type store_ff [2 * BANK];

   // whole pipe moves when the output register is free or being taken
   assign adv   = !b_valid_ff || rsp_ready;
   assign q_pop = adv && q_valid;
   assign head  = entry_type'(q_entry);

   // source raster address: (h-1-col)*w + row, plus bank offset
   assign src_sum = SW'(head.rd_base) * SW'(width) + SW'(head.rd_row) +
                    (head.rd_bank ? SW'(BANK) : SW'(0));

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else if (adv) begin
         a_valid_ff <= q_valid;
         b_valid_ff <= a_valid_ff;
      end
   end

   // payload of both stages
   always_ff @(posedge clock) begin
      if (adv) begin
         a_pix_ff     <= head.pix;
         a_wr_addr_ff <= head.wr_addr;
         a_rd_addr_ff <= src_sum[ADDR_W-1:0];
         a_rd_on_ff   <= head.rd_on;
         a_last_ff    <= head.last;
         b_rd_on_ff   <= a_rd_on_ff;
         b_last_ff    <= a_last_ff;
      end
   end

   // frame store: read of the old bank and write of the new one in the same stage
   always_ff @(posedge clock) begin
      if (adv && a_valid_ff) begin
         store_ff[a_wr_addr_ff] <= a_pix_ff;
      end
      if (adv) begin
         rd_data_ff <= store_ff[a_rd_addr_ff];
      end
   end

   // result item, zeroed while no complete frame exists
   always_comb begin
      rsp_valid           = b_valid_ff;
      rsp_data.out_red    = b_rd_on_ff ? rd_data_ff.red : 8'd0;
      rsp_data.out_green  = b_rd_on_ff ? rd_data_ff.green : 8'd0;
      rsp_data.out_blue   = b_rd_on_ff ? rd_data_ff.blue : 8'd0;
      rsp_data.out_valid  = b_rd_on_ff;
      rsp_data.out_last   = b_last_ff;
   end

   assert property (@(posedge clock) disable iff (reset)
      (adv && a_valid_ff) |=> b_valid_ff)
      else $error("item lost between address and memory stage");

   assert property (@(posedge clock) disable iff (reset)
      (b_valid_ff && b_last_ff) |-> b_rd_on_ff)
      else $error("frame end flagged without a previous frame");

endmodule

// ===== hw/rtl/image_rotate_clockwise.sv =====
// image_rotate_clockwise: top level of the 90 degree clockwise pixel rotator
// depends on rot_pkg, rot_front, rot_queue, rot_back
//
// Usage:
//   req_*  : raster pixels of the incoming frame (valid/ready), one item per pixel.
//   rsp_*  : one item per accepted pixel, carrying a pixel of the previous frame
//            in rotated order; out_valid is low during the first frame, so a
//            dummy frame flushes the last real one. out_last marks frame end.
//   csr_*  : register writes, index 0 frame_width, 1 frame_height (1..max,
//            0 counts as 1, larger values saturate). Write only while idle.
// Throughput: one item per clock. After each register write the input side
//   is held in the following cycle while the frame size product is recomputed.
// Path: an accepted item passes through its queue slot, the address multiply
//   stage and the registered frame store read before its result shows.
// Stalls: the output register holds while rsp_ready is low; a four-entry
//   queue lets pixels keep arriving until it fills, then req_ready drops.
// Reset: counters clear, size returns to 64x64 (saturated), no frame is
//   ready; the frame store needs no clearing pass.

module image_rotate_clockwise #(
   parameter int MAX_WIDTH  = 64,
   parameter int MAX_HEIGHT = 64
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  rot_pkg::pixel_type               req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output rot_pkg::result_type              rsp_data,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [rot_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [rot_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   localparam int WW      = $clog2(MAX_WIDTH + 1);
   localparam int HW      = $clog2(MAX_HEIGHT + 1);
   localparam int BANK    = MAX_WIDTH * MAX_HEIGHT;
   localparam int ADDR_W  = $clog2(2 * BANK);
   localparam int ENTRY_W = 24 + ADDR_W + 3 + HW + WW;

   logic               q_full;
   logic               q_push;
   logic [ENTRY_W-1:0] q_entry;
   logic               q_valid;
   logic [ENTRY_W-1:0] q_head;
   logic               q_pop;
   logic [WW-1:0]      width;

   // registers are always writable
   assign csr_ready = 1'b1;

   rot_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_entry   (q_entry),
      .width     (width)
   );

   rot_queue #(
      .DATA_W (ENTRY_W),
      .DEPTH  (rot_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_data  (q_entry),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_data  (q_head)
   );

   rot_back #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .width     (width),
      .q_valid   (q_valid),
      .q_entry   (q_head),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
